// ===== sv/two_body_verlet_step_macros.svh =====
// Assertion macros for the two-body Verlet step block.
`ifndef TWO_BODY_VERLET_STEP_MACROS_SVH
`define TWO_BODY_VERLET_STEP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TBVS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TBVS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tbvs_pkg.sv =====
// Shared types, constants, microcode and saturation helpers for the Verlet step block.
`timescale 1ns / 1ps
`default_nettype none
package tbvs_pkg;

   localparam int FRAC_BITS_DEF = 48;
   localparam int DATA_W        = 64;
   localparam int WIDE_W        = 128;
   localparam int CFG_W         = 63;
   localparam int CSR_IDX_W     = 3;
   localparam int PC_W          = 6;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 640;

   localparam logic [CFG_W-1:0] RST_STEP_H = 63'd2814749767;
   localparam logic [CFG_W-1:0] RST_GRAV   = 63'd11112186675771662;
   localparam logic [CFG_W-1:0] RST_MASS   = 63'd844424930;
   localparam logic signed [DATA_W-1:0] RST_INIT_X  = 64'sd281474976710656;
   localparam logic signed [DATA_W-1:0] RST_INIT_Y  = 64'sd0;
   localparam logic signed [DATA_W-1:0] RST_INIT_VX = 64'sd0;
   localparam logic signed [DATA_W-1:0] RST_INIT_VY = 64'sd1768559438007110;

   localparam logic signed [DATA_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [DATA_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_H, REG_GRAV, REG_MASS, REG_INIT_X, REG_INIT_Y, REG_INIT_VX, REG_INIT_VY
   } csr_reg_type;

   typedef enum logic [3:0] {
      OP_MOV, OP_ADD, OP_SUB, OP_AVG, OP_NEG, OP_MULR, OP_MULH, OP_DIV, OP_SQRT,
      OP_JMP, OP_END
   } op_type;

   typedef enum logic [4:0] {
      S_X, S_Y, S_VX, S_VY, S_AX, S_AY, S_T, S_NX, S_NY, S_R, S_FAC,
      S_T0, S_T1, S_T2, S_T3, S_KIN, S_POT, S_TOT, S_LZ,
      S_H, S_GM, S_M, S_IX, S_IY, S_IVX, S_IVY, S_ZERO
   } sel_type;

   typedef struct packed {
      op_type              op;
      sel_type             a;
      sel_type             b;
      sel_type             d;
      logic [PC_W-1:0]     tgt;
   } uop_type;

   typedef struct packed {
      logic    start;
      logic    load_out;
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic out_full;
   } dp_stat_type;

   localparam logic [PC_W-1:0] STEP_PC = 6'd0;
   localparam logic [PC_W-1:0] EMIT_PC = 6'd27;
   localparam logic [PC_W-1:0] RST_PC  = 6'd40;

   function automatic uop_type mk(input op_type op, input sel_type a, input sel_type b,
                                  input sel_type d);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.d   = d;
      u.tgt = '0;
      return u;
   endfunction

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      u = mk(OP_END, S_ZERO, S_ZERO, S_T0);
      case (pc)
         // advance position
         6'd0:  u = mk(OP_MULR, S_H,   S_VX,  S_T0);
         6'd1:  u = mk(OP_ADD,  S_X,   S_T0,  S_T0);
         6'd2:  u = mk(OP_MULH, S_H,   S_AX,  S_T1);
         6'd3:  u = mk(OP_SUB,  S_T0,  S_T1,  S_NX);
         6'd4:  u = mk(OP_MULR, S_H,   S_VY,  S_T0);
         6'd5:  u = mk(OP_ADD,  S_Y,   S_T0,  S_T0);
         6'd6:  u = mk(OP_MULH, S_H,   S_AY,  S_T1);
         6'd7:  u = mk(OP_SUB,  S_T0,  S_T1,  S_NY);
         6'd8:  u = mk(OP_SQRT, S_NX,  S_NY,  S_R);
         // new acceleration terms
         6'd9:  u = mk(OP_MULR, S_H,   S_GM,  S_FAC);
         6'd10: u = mk(OP_MULR, S_FAC, S_NX,  S_T0);
         6'd11: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd12: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd13: u = mk(OP_DIV,  S_T0,  S_R,   S_T2);
         6'd14: u = mk(OP_MULR, S_FAC, S_NY,  S_T0);
         6'd15: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd16: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd17: u = mk(OP_DIV,  S_T0,  S_R,   S_T3);
         // velocity and state commit
         6'd18: u = mk(OP_AVG,  S_AX,  S_T2,  S_T0);
         6'd19: u = mk(OP_SUB,  S_VX,  S_T0,  S_VX);
         6'd20: u = mk(OP_AVG,  S_AY,  S_T3,  S_T0);
         6'd21: u = mk(OP_SUB,  S_VY,  S_T0,  S_VY);
         6'd22: u = mk(OP_MOV,  S_NX,  S_ZERO, S_X);
         6'd23: u = mk(OP_MOV,  S_NY,  S_ZERO, S_Y);
         6'd24: u = mk(OP_MOV,  S_T2,  S_ZERO, S_AX);
         6'd25: u = mk(OP_MOV,  S_T3,  S_ZERO, S_AY);
         6'd26: u = mk(OP_ADD,  S_T,   S_H,   S_T);
         // report row
         6'd27: u = mk(OP_MULR, S_VX,  S_VX,  S_T0);
         6'd28: u = mk(OP_MULR, S_VY,  S_VY,  S_T1);
         6'd29: u = mk(OP_ADD,  S_T0,  S_T1,  S_T0);
         6'd30: u = mk(OP_MULH, S_M,   S_T0,  S_KIN);
         6'd31: u = mk(OP_MULR, S_GM,  S_M,   S_T0);
         6'd32: u = mk(OP_NEG,  S_T0,  S_ZERO, S_T0);
         6'd33: u = mk(OP_DIV,  S_T0,  S_R,   S_POT);
         6'd34: u = mk(OP_MULR, S_X,   S_VY,  S_T0);
         6'd35: u = mk(OP_MULR, S_Y,   S_VX,  S_T1);
         6'd36: u = mk(OP_SUB,  S_T0,  S_T1,  S_T0);
         6'd37: u = mk(OP_MULR, S_M,   S_T0,  S_LZ);
         6'd38: u = mk(OP_ADD,  S_KIN, S_POT, S_TOT);
         6'd39: u = mk(OP_END,  S_ZERO, S_ZERO, S_T0);
         // restart load
         6'd40: u = mk(OP_MOV,  S_IX,  S_ZERO, S_X);
         6'd41: u = mk(OP_MOV,  S_IY,  S_ZERO, S_Y);
         6'd42: u = mk(OP_MOV,  S_IVX, S_ZERO, S_VX);
         6'd43: u = mk(OP_MOV,  S_IVY, S_ZERO, S_VY);
         6'd44: u = mk(OP_MOV,  S_ZERO, S_ZERO, S_T);
         6'd45: u = mk(OP_SQRT, S_X,   S_Y,   S_R);
         6'd46: u = mk(OP_MULR, S_H,   S_GM,  S_FAC);
         6'd47: u = mk(OP_MULR, S_FAC, S_X,   S_T0);
         6'd48: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd49: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd50: u = mk(OP_DIV,  S_T0,  S_R,   S_AX);
         6'd51: u = mk(OP_MULR, S_FAC, S_Y,   S_T0);
         6'd52: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd53: u = mk(OP_DIV,  S_T0,  S_R,   S_T0);
         6'd54: u = mk(OP_DIV,  S_T0,  S_R,   S_AY);
         6'd55: begin
            u     = mk(OP_JMP, S_ZERO, S_ZERO, S_T0);
            u.tgt = EMIT_PC;
         end
         default: u = mk(OP_END, S_ZERO, S_ZERO, S_T0);
      endcase
      return u;
   endfunction

   // Signed result from sign and 128-bit magnitude, clamped to 64 bits.
   function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                         input logic [WIDE_W-1:0] m);
      logic [DATA_W-1:0] lo;
      lo = m[DATA_W-1:0];
      if (neg) begin
         if (m[WIDE_W-1:DATA_W] != '0 || lo > S64_MIN) return S64_MIN;
         return 64'd0 - lo;
      end
      if (m[WIDE_W-1:DATA_W] != '0 || lo > S64_MAX) return S64_MAX;
      return lo;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat65(input logic signed [DATA_W:0] s);
      if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? S64_MIN : S64_MAX;
      return s[DATA_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/tbvs_mul.sv =====
// Serial 64x64 unsigned multiplier: one 32x32 partial product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tbvs_mul import tbvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DATA_W-1:0]   a,
   input  logic [DATA_W-1:0]   b,
   output logic                done,
   output logic [WIDE_W-1:0]   prod
);

   logic                busy_ff;
   logic                done_ff;
   logic [1:0]          step_ff;
   logic [DATA_W-1:0]   a_ff;
   logic [DATA_W-1:0]   b_ff;
   logic [WIDE_W-1:0]   acc_ff;
   logic [31:0]         ah;
   logic [31:0]         bh;
   logic [DATA_W-1:0]   pp;
   logic [WIDE_W-1:0]   pp_sh;

   always_comb begin
      ah = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      bh = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = DATA_W'(ah) * DATA_W'(bh);
      case (step_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + pp_sh;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// ===== sv/tbvs_iter.sv =====
// Shared bit-serial unit: rounded fixed-point division and integer square root.
`timescale 1ns / 1ps
`default_nettype none
module tbvs_iter import tbvs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      sqrt_mode,
   input  logic [DATA_W-1:0]         num,
   input  logic                      neg,
   input  logic [DATA_W-1:0]         den,
   input  logic [WIDE_W-1:0]         rad,
   output logic                      done,
   output logic signed [DATA_W-1:0]  res
);

   localparam int DIV_STEPS = DATA_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {IT_IDLE, IT_DIV, IT_SQRT, IT_FIN} it_state_type;

   it_state_type               st_ff;
   logic                       done_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [WIDE_W-1:0]          nreg_ff;
   logic [DATA_W+1:0]          rem_ff;
   logic [WIDE_W-1:0]          q_ff;
   logic                       neg_ff;
   logic                       sq_ff;
   logic [DATA_W-1:0]          den_ff;
   logic signed [DATA_W-1:0]   res_ff;

   logic [DATA_W:0]            drem_sh;
   logic                       dge;
   logic [DATA_W+3:0]          srem_sh;
   logic [DATA_W+3:0]          trial;
   logic                       sge;
   logic                       rnd;

   always_comb begin
      drem_sh = {rem_ff[DATA_W-1:0], nreg_ff[WIDE_W-1]};
      dge     = drem_sh >= {1'b0, den_ff};
      srem_sh = {rem_ff, nreg_ff[WIDE_W-1:WIDE_W-2]};
      trial   = {2'b00, q_ff[DATA_W-1:0], 2'b01};
      sge     = srem_sh >= trial;
      rnd     = {rem_ff[DATA_W:0], 1'b0} >= {2'b00, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= IT_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            IT_IDLE: begin
               if (start) begin
                  if (sqrt_mode) begin
                     st_ff  <= IT_SQRT;
                     cnt_ff <= CNT_W'(DATA_W);
                  end else if (num == '0 || den == '0) begin
                     done_ff <= 1'b1;
                  end else begin
                     st_ff  <= IT_DIV;
                     cnt_ff <= CNT_W'(DIV_STEPS);
                  end
               end
            end
            IT_DIV, IT_SQRT: begin
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) st_ff <= IT_FIN;
            end
            IT_FIN: begin
               st_ff   <= IT_IDLE;
               done_ff <= 1'b1;
            end
            default: st_ff <= IT_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         IT_IDLE: begin
            if (start) begin
               sq_ff   <= sqrt_mode;
               neg_ff  <= neg;
               den_ff  <= den;
               rem_ff  <= '0;
               q_ff    <= '0;
               nreg_ff <= sqrt_mode ? rad : {num, 64'd0};
               if (!sqrt_mode && num == '0) res_ff <= '0;
               else if (!sqrt_mode && den == '0) res_ff <= neg ? S64_MIN : S64_MAX;
            end
         end
         IT_DIV: begin
            rem_ff  <= dge ? {1'b0, drem_sh - {1'b0, den_ff}} : {1'b0, drem_sh};
            q_ff    <= {q_ff[WIDE_W-2:0], dge};
            nreg_ff <= {nreg_ff[WIDE_W-2:0], 1'b0};
         end
         IT_SQRT: begin
            rem_ff  <= sge ? (DATA_W+2)'(srem_sh - trial)
                           : srem_sh[DATA_W+1:0];
            q_ff    <= {q_ff[WIDE_W-2:0], sge};
            nreg_ff <= {nreg_ff[WIDE_W-3:0], 2'b00};
         end
         IT_FIN: begin
            if (sq_ff) res_ff <= q_ff[DATA_W-1] ? S64_MAX : q_ff[DATA_W-1:0];
            else       res_ff <= sat_mag(neg_ff, q_ff + WIDE_W'(rnd));
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule
`default_nettype wire

// ===== sv/tbvs_dp.sv =====
// Datapath: state and configuration registers, arithmetic units and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tbvs_dp import tbvs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata
);

   typedef enum logic [2:0] {PH_IDLE, PH_GO, PH_MUL, PH_SQA, PH_SQB, PH_ITER} ph_type;

   logic signed [DATA_W-1:0] x_ff, y_ff, vx_ff, vy_ff, ax_ff, ay_ff, t_ff, nx_ff, ny_ff;
   logic signed [DATA_W-1:0] r_ff, fac_ff, t0_ff, t1_ff, t2_ff, t3_ff;
   logic signed [DATA_W-1:0] kin_ff, pot_ff, tot_ff, lz_ff;
   logic [CFG_W-1:0]         h_ff, gm_ff, m_ff;
   logic signed [DATA_W-1:0] ix_ff, iy_ff, ivx_ff, ivy_ff;

   ph_type                   ph_ff, ph_in;
   op_type                   op_ff;
   sel_type                  d_ff;
   logic signed [DATA_W-1:0] a_ff, b_ff;
   logic [WIDE_W-1:0]        n_ff, n_in;
   logic                     done_ff, done_in;
   logic                     rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff;

   logic [DATA_W-1:0]        mag_a, mag_b;
   logic                     mul_start, mul_done;
   logic [DATA_W-1:0]        mul_a, mul_b;
   logic [WIDE_W-1:0]        mul_prod;
   logic                     iter_start, iter_sqrt, iter_done;
   logic [WIDE_W-1:0]        iter_rad;
   logic signed [DATA_W-1:0] iter_res;
   logic                     wr_en;
   logic signed [DATA_W-1:0] wr_val, alu_val, round_val;
   logic [WIDE_W-1:0]        rnd_lo, rnd_hi;

   function automatic logic signed [DATA_W-1:0] src_val(input sel_type s);
      case (s)
         S_X:     return x_ff;
         S_Y:     return y_ff;
         S_VX:    return vx_ff;
         S_VY:    return vy_ff;
         S_AX:    return ax_ff;
         S_AY:    return ay_ff;
         S_T:     return t_ff;
         S_NX:    return nx_ff;
         S_NY:    return ny_ff;
         S_R:     return r_ff;
         S_FAC:   return fac_ff;
         S_T0:    return t0_ff;
         S_T1:    return t1_ff;
         S_T2:    return t2_ff;
         S_T3:    return t3_ff;
         S_KIN:   return kin_ff;
         S_POT:   return pot_ff;
         S_TOT:   return tot_ff;
         S_LZ:    return lz_ff;
         S_H:     return {1'b0, h_ff};
         S_GM:    return {1'b0, gm_ff};
         S_M:     return {1'b0, m_ff};
         S_IX:    return ix_ff;
         S_IY:    return iy_ff;
         S_IVX:   return ivx_ff;
         S_IVY:   return ivy_ff;
         default: return '0;
      endcase
   endfunction

   tbvs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   tbvs_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
      .clock     (clock),
      .reset     (reset),
      .start     (iter_start),
      .sqrt_mode (iter_sqrt),
      .num       (mag_a),
      .neg       (a_ff[DATA_W-1]),
      .den       (b_ff),
      .rad       (iter_rad),
      .done      (iter_done),
      .res       (iter_res)
   );

   always_comb begin
      mag_a  = a_ff[DATA_W-1] ? 64'd0 - a_ff : a_ff;
      mag_b  = b_ff[DATA_W-1] ? 64'd0 - b_ff : b_ff;
      rnd_lo = (mul_prod + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      rnd_hi = (mul_prod + (WIDE_W'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
      round_val = sat_mag(a_ff[DATA_W-1] ^ b_ff[DATA_W-1],
                          (op_ff == OP_MULH) ? rnd_hi : rnd_lo);
      case (op_ff)
         OP_ADD:  alu_val = sat65({a_ff[DATA_W-1], a_ff} + {b_ff[DATA_W-1], b_ff});
         OP_SUB:  alu_val = sat65({a_ff[DATA_W-1], a_ff} - {b_ff[DATA_W-1], b_ff});
         OP_AVG:  alu_val = DATA_W'(({a_ff[DATA_W-1], a_ff} + {b_ff[DATA_W-1], b_ff}) >>> 1);
         OP_NEG:  alu_val = 64'd0 - a_ff;
         default: alu_val = a_ff;
      endcase
   end

   always_comb begin
      ph_in      = ph_ff;
      n_in       = n_ff;
      done_in    = 1'b0;
      mul_start  = 1'b0;
      mul_a      = mag_a;
      mul_b      = mag_b;
      iter_start = 1'b0;
      iter_sqrt  = 1'b0;
      iter_rad   = n_ff + mul_prod;
      wr_en      = 1'b0;
      wr_val     = alu_val;
      case (ph_ff)
         PH_IDLE: if (cmd.start) ph_in = PH_GO;
         PH_GO: begin
            case (op_ff)
               OP_MULR, OP_MULH: begin
                  mul_start = 1'b1;
                  ph_in     = PH_MUL;
               end
               OP_SQRT: begin
                  mul_start = 1'b1;
                  mul_b     = mag_a;
                  ph_in     = PH_SQA;
               end
               OP_DIV: begin
                  iter_start = 1'b1;
                  ph_in      = PH_ITER;
               end
               default: begin
                  wr_en   = 1'b1;
                  done_in = 1'b1;
                  ph_in   = PH_IDLE;
               end
            endcase
         end
         PH_MUL: begin
            if (mul_done) begin
               wr_en   = 1'b1;
               wr_val  = round_val;
               done_in = 1'b1;
               ph_in   = PH_IDLE;
            end
         end
         PH_SQA: begin
            mul_a = mag_b;
            mul_b = mag_b;
            if (mul_done) begin
               n_in      = mul_prod;
               mul_start = 1'b1;
               ph_in     = PH_SQB;
            end
         end
         PH_SQB: begin
            if (mul_done) begin
               iter_start = 1'b1;
               iter_sqrt  = 1'b1;
               ph_in      = PH_ITER;
            end
         end
         PH_ITER: begin
            if (iter_done) begin
               wr_en   = 1'b1;
               wr_val  = iter_res;
               done_in = 1'b1;
               ph_in   = PH_IDLE;
            end
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff         <= PH_IDLE;
         done_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
         if (cmd.load_out)    rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      if (ph_ff == PH_IDLE && cmd.start) begin
         op_ff <= cmd.uop.op;
         d_ff  <= cmd.uop.d;
         a_ff  <= src_val(cmd.uop.a);
         b_ff  <= src_val(cmd.uop.b);
      end
      if (cmd.load_out) begin
         rsp_tdata_ff <= {2'b00, lz_ff, tot_ff, pot_ff, kin_ff[CFG_W-1:0], vy_ff, vx_ff,
                          r_ff[CFG_W-1:0], y_ff, x_ff, t_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (d_ff)
            S_X:     x_ff   <= wr_val;
            S_Y:     y_ff   <= wr_val;
            S_VX:    vx_ff  <= wr_val;
            S_VY:    vy_ff  <= wr_val;
            S_AX:    ax_ff  <= wr_val;
            S_AY:    ay_ff  <= wr_val;
            S_T:     t_ff   <= wr_val;
            S_NX:    nx_ff  <= wr_val;
            S_NY:    ny_ff  <= wr_val;
            S_R:     r_ff   <= wr_val;
            S_FAC:   fac_ff <= wr_val;
            S_T0:    t0_ff  <= wr_val;
            S_T1:    t1_ff  <= wr_val;
            S_T2:    t2_ff  <= wr_val;
            S_T3:    t3_ff  <= wr_val;
            S_KIN:   kin_ff <= wr_val;
            S_POT:   pot_ff <= wr_val;
            S_TOT:   tot_ff <= wr_val;
            S_LZ:    lz_ff  <= wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff   <= RST_STEP_H;
         gm_ff  <= RST_GRAV;
         m_ff   <= RST_MASS;
         ix_ff  <= RST_INIT_X;
         iy_ff  <= RST_INIT_Y;
         ivx_ff <= RST_INIT_VX;
         ivy_ff <= RST_INIT_VY;
      end else if (csr_write) begin
         case (csr_index)
            REG_STEP_H:  h_ff   <= csr_wdata[CFG_W-1:0];
            REG_GRAV:    gm_ff  <= csr_wdata[CFG_W-1:0];
            REG_MASS:    m_ff   <= csr_wdata[CFG_W-1:0];
            REG_INIT_X:  ix_ff  <= csr_wdata;
            REG_INIT_Y:  iy_ff  <= csr_wdata;
            REG_INIT_VX: ivx_ff <= csr_wdata;
            REG_INIT_VY: ivy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign stat.done     = done_ff;
   assign stat.out_full = rsp_tvalid_ff;
   assign rsp_tvalid    = rsp_tvalid_ff;
   assign rsp_tdata     = rsp_tdata_ff;

endmodule
`default_nettype wire

// ===== sv/tbvs_ctrl.sv =====
// Controller: steps through the microcode, issuing one operation at a time to the datapath.
`timescale 1ns / 1ps
`default_nettype none
module tbvs_ctrl import tbvs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_restart,
   output logic         req_tready,
   output dp_cmd_type   cmd,
   input  dp_stat_type  stat
);

   typedef enum logic [1:0] {CS_IDLE, CS_ISSUE, CS_WAIT, CS_OUT} cs_type;

   cs_type            state_ff;
   logic [PC_W-1:0]   pc_ff;
   logic              silent_ff;
   uop_type           uop;

   assign uop = ucode(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         // boot runs the restart program without reporting
         state_ff  <= CS_ISSUE;
         pc_ff     <= RST_PC;
         silent_ff <= 1'b1;
      end else begin
         case (state_ff)
            CS_IDLE: begin
               if (req_tvalid) begin
                  pc_ff     <= req_restart ? RST_PC : STEP_PC;
                  silent_ff <= 1'b0;
                  state_ff  <= CS_ISSUE;
               end
            end
            CS_ISSUE: begin
               case (uop.op)
                  OP_JMP: pc_ff <= uop.tgt;
                  OP_END: state_ff <= silent_ff ? CS_IDLE : CS_OUT;
                  default: state_ff <= CS_WAIT;
               endcase
            end
            CS_WAIT: begin
               if (stat.done) begin
                  pc_ff    <= pc_ff + PC_W'(1);
                  state_ff <= CS_ISSUE;
               end
            end
            CS_OUT: if (!stat.out_full) state_ff <= CS_IDLE;
            default: state_ff <= CS_IDLE;
         endcase
      end
   end

   always_comb begin
      req_tready   = (state_ff == CS_IDLE);
      cmd.uop      = uop;
      cmd.start    = (state_ff == CS_ISSUE) && (uop.op != OP_JMP) && (uop.op != OP_END);
      cmd.load_out = (state_ff == CS_OUT) && !stat.out_full;
   end

endmodule
`default_nettype wire

// ===== sv/two_body_verlet_step.sv =====
// Top level of the two-body velocity Verlet orbit stepper.
`timescale 1ns / 1ps
`default_nettype none
// One request transaction either restarts the orbit from the initial-value registers
// (restart = 1) or advances it one time step, and yields one row: time, position,
// radius, velocity, energies and angular momentum, all signed fixed point with
// FRAC_BITS fraction bits. Items are handled one at a time. The run time is dominated by
// seven rounded divisions on the shared one-bit-per-cycle divide/square-root unit, next
// to a 64-step square root and a serial multiplier per product; a division with a zero
// dividend or radius skips its iterations. After reset the block loads the default orbit
// and computes its start acceleration, a similar run during which req_tready stays low.
// Configuration writes are taken only while the block is idle (csr_ready follows
// req_tready). A finished row waits in the output register while the next request is
// taken.
module two_body_verlet_step import tbvs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,   // [0] restart
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // sim_time, pos_x, pos_y, radius(63), vel_x, vel_y, kinetic_energy(63),
   // potential_energy, total_energy, angular_momentum, zero pad
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

`include "two_body_verlet_step_macros.svh"

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_ready = req_tready;

   tbvs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .cmd         (dp_cmd),
      .stat        (dp_stat)
   );

   tbvs_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `TBVS_ASSERT_NOW(a_no_overwrite, dp_cmd.load_out, !dp_stat.out_full, "pending row overwritten")
   `TBVS_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "took a second item")
   `TBVS_ASSERT_NEXT(a_load_shows, dp_cmd.load_out, rsp_tvalid, "loaded row not presented")
   `TBVS_ASSERT_NOW(a_start_busy, dp_cmd.start, !req_tready, "operation issued while idle")

endmodule
`default_nettype wire

// ===== sim/tb_two_body_verlet_step.sv =====
// Testbench for the two-body Verlet orbit stepper: predicts each row and checks the stream.
`timescale 1ns / 1ps
`default_nettype none

class orbit_scoreboard;
   localparam logic signed [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int FRAC = 48;

   logic [63:0] step_h, grav, mass;
   logic signed [63:0] ini_x, ini_y, ini_vx, ini_vy;
   logic signed [63:0] px, py, vx, vy, ahx, ahy, t_now;
   logic [639:0] rows_due[$];
   int errors;

   function new();
      errors = 0;
      step_h = 64'd2814749767;
      grav = 64'd11112186675771662;
      mass = 64'd844424930;
      ini_x = 64'sd281474976710656;
      ini_y = 0;
      ini_vx = 0;
      ini_vy = 64'sd1768559438007110;
      load_orbit();
   endfunction

   function logic signed [63:0] clamp(bit neg, logic [127:0] m);
      if (neg) begin
         if (m > 128'h8000_0000_0000_0000) return SMIN;
         return 64'd0 - m[63:0];
      end
      if (m > 128'h7FFF_FFFF_FFFF_FFFF) return SMAX;
      return m[63:0];
   endfunction

   function logic [63:0] absval(logic signed [63:0] a);
      return a[63] ? 64'd0 - a : a;
   endfunction

   function logic signed [63:0] mul_shift(logic signed [63:0] a, logic signed [63:0] b,
                                          int sh);
      logic [127:0] p;
      p = {64'd0, absval(a)} * {64'd0, absval(b)} + (128'd1 << (sh - 1));
      p = p >> sh;
      return clamp(a[63] != b[63], p);
   endfunction

   function logic signed [63:0] fx_div(logic signed [63:0] a, logic [63:0] d);
      logic [127:0] n, q, r;
      if (a == 0) return 0;
      if (d == 0) return a[63] ? SMIN : SMAX;
      n = {64'd0, absval(a)} << FRAC;
      q = n / {64'd0, d};
      r = n % {64'd0, d};
      if (r >= {64'd0, d} - r) q = q + 1;
      return clamp(a[63], q);
   endfunction

   function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
   endfunction

   function logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
   endfunction

   function logic signed [63:0] mean_floor(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      return s[64:1];
   endfunction

   function logic [63:0] radius_of(logic signed [63:0] x, logic signed [63:0] y);
      logic [127:0] n;
      logic [63:0] root, c;
      n = {64'd0, absval(x)} * {64'd0, absval(x)} + {64'd0, absval(y)} * {64'd0, absval(y)};
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         c = root | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) root = c;
      end
      return root > MASK63 ? MASK63 : root;
   endfunction

   function logic signed [63:0] pull_term(logic signed [63:0] p, logic [63:0] r);
      logic signed [63:0] fac;
      fac = mul_shift(step_h, grav, FRAC);
      return fx_div(fx_div(fx_div(mul_shift(fac, p, FRAC), r), r), r);
   endfunction

   function void load_orbit();
      logic [63:0] r;
      px = ini_x; py = ini_y; vx = ini_vx; vy = ini_vy;
      t_now = 0;
      r = radius_of(px, py);
      ahx = pull_term(px, r);
      ahy = pull_term(py, r);
   endfunction

   function logic [639:0] orbit_row(logic [63:0] r);
      logic signed [63:0] v2, kin, pot, lz;
      logic [63:0] f[10];
      logic [639:0] row;
      int pos;
      v2 = sat_add(mul_shift(vx, vx, FRAC), mul_shift(vy, vy, FRAC));
      kin = mul_shift(mass, v2, FRAC + 1);
      pot = fx_div(-mul_shift(grav, mass, FRAC), r);
      lz = mul_shift(mass, sat_sub(mul_shift(px, vy, FRAC), mul_shift(py, vx, FRAC)), FRAC);
      f = '{t_now, px, py, r & MASK63, vx, vy, kin & MASK63, pot, sat_add(kin, pot), lz};
      row = '0;
      pos = 0;
      for (int i = 0; i < 10; i++) begin
         row |= 640'(f[i]) << pos;
         pos += (i == 3 || i == 6) ? 63 : 64;
      end
      return row;
   endfunction

   function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
         tbvs_pkg::REG_STEP_H:  step_h = data & MASK63;
         tbvs_pkg::REG_GRAV:    grav = data & MASK63;
         tbvs_pkg::REG_MASS:    mass = data & MASK63;
         tbvs_pkg::REG_INIT_X:  ini_x = data;
         tbvs_pkg::REG_INIT_Y:  ini_y = data;
         tbvs_pkg::REG_INIT_VX: ini_vx = data;
         tbvs_pkg::REG_INIT_VY: ini_vy = data;
         default: ;
      endcase
   endfunction

   function void note_input(bit restart);
      logic signed [63:0] nx, ny, ax, ay;
      logic [63:0] r;
      if (restart) begin
         load_orbit();
         rows_due.push_back(orbit_row(radius_of(px, py)));
         return;
      end
      nx = sat_sub(sat_add(px, mul_shift(step_h, vx, FRAC)), mul_shift(step_h, ahx, FRAC + 1));
      ny = sat_sub(sat_add(py, mul_shift(step_h, vy, FRAC)), mul_shift(step_h, ahy, FRAC + 1));
      r = radius_of(nx, ny);
      ax = pull_term(nx, r);
      ay = pull_term(ny, r);
      vx = sat_sub(vx, mean_floor(ahx, ax));
      vy = sat_sub(vy, mean_floor(ahy, ay));
      px = nx; py = ny; ahx = ax; ahy = ay;
      t_now = sat_add(t_now, step_h);
      rows_due.push_back(orbit_row(r));
   endfunction

   function void check_row(logic [639:0] got, realtime now);
      string names[10] = '{"sim_time", "pos_x", "pos_y", "radius", "vel_x", "vel_y",
                           "kinetic_energy", "potential_energy", "total_energy",
                           "angular_momentum"};
      logic [639:0] want;
      logic [63:0] w, a, m;
      int pos;
      if (rows_due.size() == 0) begin
         $display("%0t: unexpected result transaction %h", now, got);
         errors++;
         return;
      end
      want = rows_due.pop_front();
      pos = 0;
      for (int i = 0; i < 10; i++) begin
         m = (i == 3 || i == 6) ? MASK63 : 64'hFFFF_FFFF_FFFF_FFFF;
         w = 64'(want >> pos) & m;
         a = 64'(got >> pos) & m;
         if (w !== a) begin
            $display("%0t: %s expected %h actual %h", now, names[i], w, a);
            errors++;
         end
         pos += (i == 3 || i == 6) ? 63 : 64;
      end
   endfunction
endclass

module tb_two_body_verlet_step;
   import tbvs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 1500;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, csr_valid, csr_ready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wdata;

   orbit_scoreboard sb;
   int send_idle_pct, recv_stall_pct, quiet_cycles;

   two_body_verlet_step i_dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            sb.check_row(rsp_tdata, $realtime);
            quiet_cycles = 0;
         end
         if (req_tvalid && req_tready) begin
            sb.note_input(req_tdata[0]);
            quiet_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_wdata);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL two_body_verlet_step");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_tick(bit restart);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
   endtask

   // drain outstanding rows before touching the registers
   task automatic settle();
      req_tvalid <= 0;
      while (sb.rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_orbit(logic [63:0] h, logic [63:0] gm, logic [63:0] m,
                            logic [63:0] x, logic [63:0] y, logic [63:0] u, logic [63:0] v);
      csr_write(REG_STEP_H, h);
      csr_write(REG_GRAV, gm);
      csr_write(REG_MASS, m);
      csr_write(REG_INIT_X, x);
      csr_write(REG_INIT_Y, y);
      csr_write(REG_INIT_VX, u);
      csr_write(REG_INIT_VY, v);
   endtask

   function automatic logic [63:0] near_unit();
      logic signed [63:0] v;
      v = $signed({32'd0, 32'($urandom_range(0, 262144))}) - 64'sd131072;
      return v <<< 31;
   endfunction

   function automatic logic [63:0] any64();
      case ($urandom_range(0, 3))
         0: return 64'h7FFF_FFFF_FFFF_FFFF;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'd0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_phase(int items);
      if ($urandom_range(0, 3) != 0)
         set_orbit(64'($urandom_range(1 << 20, 32'h7FFF_FFFF)) << 10,
                   RST_GRAV + 64'($urandom_range(0, 1 << 30)) - 64'd536870912,
                   64'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 20),
                   near_unit(), near_unit(), near_unit() << 2, near_unit() << 2);
      else
         set_orbit(any64(), any64(), any64(), any64(), any64(), any64(), any64());
      send_tick(1);
      for (int i = 1; i < items; i++) send_tick($urandom_range(0, 99) < 4);
      settle();
   endtask

   initial begin
      int idle_modes[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{13, 13}};
      sb = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      quiet_cycles = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // default orbit from reset, then a restart
      repeat (4) send_tick(0);
      send_tick(1);
      repeat (3) send_tick(0);
      settle();

      // register extremes with top bits that must be dropped
      set_orbit(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      csr_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_tick(1);
      repeat (3) send_tick(0);
      settle();

      // body at the origin: zero radius
      set_orbit(RST_STEP_H, RST_GRAV, RST_MASS, 64'd0, 64'd0, 64'd0, 64'd0);
      send_tick(1);
      repeat (2) send_tick(0);
      settle();

      // overflowing acceleration near the origin, all bits high mass and gm
      set_orbit(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
      send_tick(1);
      repeat (2) send_tick(0);
      settle();

      for (int p = 0; p < 16; p++) begin
         send_idle_pct = idle_modes[p % 4][0];
         recv_stall_pct = idle_modes[p % 4][1];
         random_phase($urandom_range(80, 120));
      end

      if (sb.errors == 0)
         $display("PASS two_body_verlet_step");
      else
         $display("FAIL two_body_verlet_step");
      $finish;
   end
endmodule

`default_nettype wire
